[design/ffhtr_pkg.sv]
package ffhtr_pkg;

  typedef logic [7:0] byte_t;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_HDR_FIRST  = 2'd0;
  localparam cfg_addr_t CFG_HDR_SECOND = 2'd1;
  localparam cfg_addr_t CFG_TRAILER    = 2'd2;

  // Register reset values
  localparam byte_t HDR_FIRST_RST  = 8'hAA;
  localparam byte_t HDR_SECOND_RST = 8'hA1;
  localparam byte_t TRAILER_RST    = 8'hEE;

endpackage

[design/ffhtr_if.sv]
interface ffhtr_rx_if;
  logic                 valid;
  logic                 ready;
  ffhtr_pkg::byte_t     rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffhtr_frame_if;
  logic                 valid;
  logic                 ready;
  ffhtr_pkg::byte_t     frame_byte;
  logic                 frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ffhtr_cfg_if;
  logic                 valid;
  logic                 ready;
  ffhtr_pkg::cfg_addr_t addr;
  ffhtr_pkg::byte_t     data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[design/ffhtr_frame_ram.sv]
module ffhtr_frame_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ffhtr_pkg::byte_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output ffhtr_pkg::byte_t rdata
);

  ffhtr_pkg::byte_t mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ffhtr_rx_check.sv]
module ffhtr_rx_check #(
  parameter int FRAME_LEN = 16,
  parameter int AW        = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  ffhtr_pkg::byte_t rx_byte,
  input  ffhtr_pkg::byte_t hdr_first,
  input  ffhtr_pkg::byte_t hdr_second,
  input  ffhtr_pkg::byte_t trailer,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output ffhtr_pkg::byte_t wdata,
  output logic             start
);

  localparam logic [AW-1:0] POS_LAST    = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] POS_TRAILER = AW'(FRAME_LEN - 2);
  localparam logic [AW-1:0] POS_ZERO    = '0;
  localparam logic [AW-1:0] POS_ONE     = AW'(1);

  logic [AW-1:0]    pos;
  logic [AW-1:0]    pos_next;
  ffhtr_pkg::byte_t byte0;
  ffhtr_pkg::byte_t byte1;
  ffhtr_pkg::byte_t trl;
  ffhtr_pkg::byte_t cur0;
  ffhtr_pkg::byte_t cur1;
  logic             emit;

  // Store every transfer at the current position
  assign we    = take;
  assign waddr = pos;
  assign wdata = rx_byte;
  assign start = take & emit;

  // Check header and trailer bytes against the current registers
  always_comb begin
    cur0     = (pos == POS_ZERO) ? rx_byte : byte0;
    cur1     = (pos == POS_ONE)  ? rx_byte : byte1;
    pos_next = pos + POS_ONE;
    emit     = 1'b0;
    if (cur0 != hdr_first) begin
      pos_next = POS_ZERO;
    end else if ((pos != POS_ZERO) && (cur1 != hdr_second)) begin
      pos_next = POS_ZERO;
    end else if (pos == POS_LAST) begin
      pos_next = POS_ZERO;
      emit     = (trl == trailer);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_ZERO;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  // Keep copies of the bytes that later checks compare
  always_ff @(posedge clk) begin
    if (take && (pos == POS_ZERO)) begin
      byte0 <= rx_byte;
    end
    if (take && (pos == POS_ONE)) begin
      byte1 <= rx_byte;
    end
    if (take && (pos == POS_TRAILER)) begin
      trl <= rx_byte;
    end
  end

endmodule

[design/ffhtr_readout.sv]
module ffhtr_readout #(
  parameter int FRAME_LEN = 16,
  parameter int AW        = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             re,
  output logic [AW-1:0]    raddr,
  input  ffhtr_pkg::byte_t rdata,
  output logic             out_valid,
  input  logic             out_ready,
  output ffhtr_pkg::byte_t out_byte,
  output logic             out_last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_SHOW  = 2'd2;

  localparam logic [AW-1:0] PTR_LAST = AW'(FRAME_LEN - 1);

  logic [1:0]    state;
  logic [AW-1:0] rd_ptr;

  assign busy      = (state != S_IDLE);
  assign re        = (state == S_FETCH);
  assign raddr     = rd_ptr;
  assign out_valid = (state == S_SHOW);
  assign out_byte  = rdata;
  assign out_last  = (rd_ptr == PTR_LAST);

  // Fetch each stored byte, then hold it until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_ptr <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_ptr <= '0;
          if (start) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) begin
            if (out_last) begin
              state  <= S_IDLE;
              rd_ptr <= '0;
            end else begin
              state  <= S_FETCH;
              rd_ptr <= rd_ptr + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/fixed_frame_header_trailer_receiver_unit.sv]
// Fixed-length frame receiver with header and trailer check.
// Channels: rx (sink) takes one received byte per transfer; frame (source)
// gives the bytes of an accepted frame in order, frame_last on the final one;
// cfg (sink) writes header_first_byte (0), header_second_byte (1) and
// trailer_byte (2), always ready, other addresses ignored.
// A received byte is written to the frame memory and checked against the
// header and trailer registers in the cycle in which it is taken. When the
// last byte of a good frame arrives, readout starts in the next cycle and
// steps through each output byte in a fetch state (memory read) and then a
// show state that offers it on frame; the next byte is fetched only after
// the current one has transferred.
// rx.ready is low while a frame is read out; a stall on frame holds the
// current byte in the output register and pauses the readout.
// Reset clears the byte count and readout state and loads the registers with
// 0xAA, 0xA1 and 0xEE; the frame memory needs no clearing, since every entry
// is written before it is read.
module fixed_frame_header_trailer_receiver_unit #(
  parameter int FRAME_LEN = 16
) (
  input  logic   clk,
  input  logic   rst,
  ffhtr_rx_if.sink      rx,
  ffhtr_frame_if.source frame,
  ffhtr_cfg_if.sink     cfg
);

  localparam int AW = $clog2(FRAME_LEN);

  ffhtr_pkg::byte_t hdr_first;
  ffhtr_pkg::byte_t hdr_second;
  ffhtr_pkg::byte_t trailer;

  logic             busy;
  logic             take;
  logic             we;
  logic [AW-1:0]    waddr;
  ffhtr_pkg::byte_t wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  ffhtr_pkg::byte_t rdata;
  logic             start;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= ffhtr_pkg::HDR_FIRST_RST;
      hdr_second <= ffhtr_pkg::HDR_SECOND_RST;
      trailer    <= ffhtr_pkg::TRAILER_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        ffhtr_pkg::CFG_HDR_FIRST:  hdr_first  <= cfg.data;
        ffhtr_pkg::CFG_HDR_SECOND: hdr_second <= cfg.data;
        ffhtr_pkg::CFG_TRAILER:    trailer    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Accept bytes only while no frame is being read out
  assign rx.ready = ~busy;
  assign take     = rx.valid & ~busy;

  ffhtr_rx_check #(
    .FRAME_LEN (FRAME_LEN),
    .AW        (AW)
  ) u_rx_check (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx_byte    (rx.rx_byte),
    .hdr_first  (hdr_first),
    .hdr_second (hdr_second),
    .trailer    (trailer),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .start      (start)
  );

  ffhtr_frame_ram #(
    .DEPTH (FRAME_LEN),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffhtr_readout #(
    .FRAME_LEN (FRAME_LEN),
    .AW        (AW)
  ) u_readout (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_last  (frame.frame_last)
  );

  // Input and output never transfer in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |-> !frame.valid)
    else $error("input transfer during frame readout");

  // A completed frame blocks input from the next cycle
  assert property (@(posedge clk) disable iff (rst)
    start |=> !rx.ready)
    else $error("input not blocked after frame completion");

  // Readout ends after the last byte transfers
  assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.frame_last) |=> (!frame.valid && rx.ready))
    else $error("readout continues past last byte");

  // The memory is never read and written in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("frame memory read during byte write");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

  typedef ffhtr_pkg::byte_t     byte_t;
  typedef ffhtr_pkg::cfg_addr_t cfg_addr_t;

  localparam int FRAME_LEN = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 2 * FRAME_LEN;
  localparam int ITEMS_PER_PHASE = 60;
  localparam cfg_addr_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    byte_t data;
    logic  last;
  } frame_beat_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_TRAILER,
    FR_BAD_SECOND,
    FR_BAD_FIRST,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_t;

  // Track the deframer state and hold the frame bytes it should emit
  class frame_checker;
    byte_t       hdr_first;
    byte_t       hdr_second;
    byte_t       trailer;
    byte_t       frame_mem [FRAME_LEN];
    int unsigned fill;
    frame_beat_t expected_beats [$];
    int          errors;

    function new();
      hdr_first  = ffhtr_pkg::HDR_FIRST_RST;
      hdr_second = ffhtr_pkg::HDR_SECOND_RST;
      trailer    = ffhtr_pkg::TRAILER_RST;
      fill       = 0;
      errors     = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
    endfunction

    function void set_reg(cfg_addr_t addr, byte_t data);
      case (addr)
        ffhtr_pkg::CFG_HDR_FIRST:  hdr_first = data;
        ffhtr_pkg::CFG_HDR_SECOND: hdr_second = data;
        ffhtr_pkg::CFG_TRAILER:    trailer = data;
        default: ;
      endcase
    endfunction

    // Advance by one received byte; return 1 when the byte is dropped at position zero
    function bit note_rx(byte_t b);
      int unsigned pos;
      pos = fill;
      frame_mem[pos] = b;
      fill = (frame_mem[0] == hdr_first) ? pos + 1 : 0;
      // Bad second header byte: drop the frame and clear the store
      if (fill >= 2 && frame_mem[1] != hdr_second) begin
        fill = 0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
      end
      // Full length: emit only when both checks pass, restart either way
      if (fill == FRAME_LEN) begin
        fill = 0;
        if (frame_mem[1] == hdr_second && frame_mem[FRAME_LEN-2] == trailer) begin
          for (int i = 0; i < FRAME_LEN; i++)
            expected_beats.push_back('{frame_mem[i], i == FRAME_LEN - 1});
        end
      end
      return pos == 0 && fill == 0;
    endfunction

    task flag(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_beat(byte_t data, logic last);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        flag($sformatf("frame byte %02h (last %0b) with no frame pending", data, last));
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data)
        flag($sformatf("frame_byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        flag($sformatf("frame_last %0b, expected %0b (byte %02h)", last, want.last, data));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst;
  frame_checker sb;
  int unsigned  cycle_count = 0;
  int           burst_left = 0;
  int           ready_left = 0;
  int           useful_items = 0;

  ffhtr_rx_if    rx_ch ();
  ffhtr_frame_if frame_ch ();
  ffhtr_cfg_if   cfg_ch ();

  fixed_frame_header_trailer_receiver_unit #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_ch),
    .frame(frame_ch),
    .cfg  (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Toggle frame ready in runs: short stalls, mostly short ready runs, now and then a long one
  always @(negedge clk) begin
    if (ready_left == 0) begin
      if (frame_ch.ready) begin
        frame_ch.ready <= 1'b0;
        ready_left = $urandom_range(0, 7);
      end else begin
        frame_ch.ready <= 1'b1;
        ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 10);
      end
    end else begin
      ready_left--;
    end
  end

  // Check every frame transfer
  always @(posedge clk) begin
    if (!rst && frame_ch.valid && frame_ch.ready)
      sb.check_beat(frame_ch.frame_byte, frame_ch.frame_last);
  end

  function automatic byte_t other_than(byte_t v);
    byte_t r;
    r = byte_t'($urandom_range(0, 255));
    if (r == v) r = ~v;
    return r;
  endfunction

  // Payload leans toward the header and trailer values and the extremes
  function automatic byte_t payload_byte();
    case ($urandom_range(0, 9))
      0:       return sb.hdr_first;
      1:       return sb.hdr_second;
      2:       return sb.trailer;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one byte; entered and left at a falling edge
  task automatic send_rx(input byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    if (!sb.note_rx(b)) useful_items++;
    burst_left--;
    @(negedge clk);
  endtask

  // Hold the sender until every pending frame byte is out, then let the block settle
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_addr_t addr, input byte_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(addr, data);
    @(negedge clk);
  endtask

  task automatic configure(input byte_t first, input byte_t second, input byte_t trail);
    wait_drained();
    write_reg(CFG_UNUSED, byte_t'($urandom_range(0, 255)));
    write_reg(ffhtr_pkg::CFG_HDR_FIRST, first);
    write_reg(ffhtr_pkg::CFG_HDR_SECOND, second);
    write_reg(ffhtr_pkg::CFG_TRAILER, trail);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    byte_t seq [$];
    case (kind)
      FR_NOISE: begin
        repeat ($urandom_range(1, 4)) seq.push_back(byte_t'($urandom_range(0, 255)));
      end
      FR_BAD_FIRST: begin
        seq.push_back(other_than(sb.hdr_first));
        repeat ($urandom_range(0, 3)) seq.push_back(payload_byte());
      end
      FR_BAD_SECOND: begin
        seq.push_back(sb.hdr_first);
        seq.push_back(other_than(sb.hdr_second));
        repeat ($urandom_range(0, 3)) seq.push_back(payload_byte());
      end
      FR_TRUNCATED: begin
        seq.push_back(sb.hdr_first);
        seq.push_back(sb.hdr_second);
        repeat ($urandom_range(0, 12)) seq.push_back(payload_byte());
      end
      default: begin
        seq.push_back(sb.hdr_first);
        seq.push_back(sb.hdr_second);
        repeat (FRAME_LEN - 4) seq.push_back(payload_byte());
        seq.push_back(kind == FR_GOOD ? sb.trailer : other_than(sb.trailer));
        seq.push_back(payload_byte());
      end
    endcase
    foreach (seq[i]) send_rx(seq[i]);
  endtask

  // Mostly well-formed frames; end on a partial frame so the next register change lands mid-frame
  task automatic run_phase();
    int r;
    useful_items = 0;
    while (useful_items < ITEMS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 55)      send_frame(FR_GOOD);
      else if (r < 65) send_frame(FR_BAD_TRAILER);
      else if (r < 75) send_frame(FR_BAD_SECOND);
      else if (r < 83) send_frame(FR_BAD_FIRST);
      else if (r < 90) send_frame(FR_TRUNCATED);
      else             send_frame(FR_NOISE);
    end
    send_rx(sb.hdr_first);
    send_rx(sb.hdr_second);
    send_rx(payload_byte());
  endtask

  initial begin
    byte_t frame_bytes [$];
    sb = new();
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    frame_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = ffhtr_pkg::CFG_HDR_FIRST;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wrong first header byte, then wrong second header byte
    send_rx(other_than(sb.hdr_first));
    send_rx(sb.hdr_first);
    send_rx(other_than(sb.hdr_second));

    // Good frame with extreme payload, then the same frame with a bad trailer
    frame_bytes = {ffhtr_pkg::HDR_FIRST_RST, ffhtr_pkg::HDR_SECOND_RST, 8'h00, 8'hFF};
    for (int k = 0; k < FRAME_LEN - 6; k++) frame_bytes.push_back(byte_t'(8'h11 * (k + 1)));
    frame_bytes.push_back(ffhtr_pkg::TRAILER_RST);
    frame_bytes.push_back(8'h5A);
    foreach (frame_bytes[i]) send_rx(frame_bytes[i]);
    frame_bytes[FRAME_LEN-2] = ffhtr_pkg::TRAILER_RST ^ 8'h01;
    foreach (frame_bytes[i]) send_rx(frame_bytes[i]);

    run_phase();
    configure(8'h00, 8'h00, 8'h00);
    run_phase();
    configure(8'hFF, 8'hFF, 8'hFF);
    run_phase();
    configure(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
              byte_t'($urandom_range(0, 255)));
    run_phase();
    configure(8'h00, 8'hFF, byte_t'($urandom_range(0, 255)));
    run_phase();

    wait_drained();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ffhtr_pkg.sv
design/ffhtr_if.sv
design/ffhtr_frame_ram.sv
design/ffhtr_rx_check.sv
design/ffhtr_readout.sv
design/fixed_frame_header_trailer_receiver_unit.sv
test/tb.sv
